FILE: rtl/urc_pkg.sv
// Package with the shared types and constants of the ultrasonic ranging controller.
package urc_pkg;

	localparam int ELAPSED_W = 20;
	localparam int DIST_W    = 16;
	localparam int IN_W      = 8;
	localparam int OUT_W     = 24;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;
	localparam int ECHO_BITS = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETUP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd4;

	localparam logic [19:0] PERIOD_RST  = 20'd60000;
	localparam logic [15:0] TIMEOUT_RST = 16'd30000;
	localparam logic [7:0]  SETUP_RST   = 8'd2;
	localparam logic [7:0]  PULSE_RST   = 8'd10;
	localparam logic [15:0] SCALE_RST   = 16'd17983;

	localparam logic [2:0] MODE_IDLE      = 3'd0;
	localparam logic [2:0] MODE_TRIG_LOW  = 3'd1;
	localparam logic [2:0] MODE_TRIG_HIGH = 3'd2;
	localparam logic [2:0] MODE_WAIT_RISE = 3'd3;
	localparam logic [2:0] MODE_WAIT_FALL = 3'd4;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_DONE = 2'd1;
	localparam logic [1:0] EV_FAIL = 2'd2;

	typedef struct packed {
		logic [19:0] period;
		logic [15:0] timeout;
		logic [7:0]  setup;
		logic [7:0]  pulse;
		logic [15:0] scale;
	} urc_cfg_t;

	typedef struct packed {
		logic [1:0]        ev;
		logic              valid;
		logic [DIST_W-1:0] distance;
		logic              trig;
	} urc_res_t;

endpackage

FILE: rtl/ultrasonic_ranging_controller_unit.sv
// Top level of the ultrasonic ranging controller: configuration registers, lanes and result bank.
// Each input item is one microsecond tick with the echo level of every sensor, and it yields
// one result item per sensor, sensor 0 first, with tlast on the result of the last sensor.
// All sensor lanes step together in the cycle the tick is accepted; the width-to-distance
// multiply works combinationally on the lane's stage registers, and the results of a tick
// are then loaded into the result bank, which presents them once it is free. Results leave
// through a single output port at one per cycle while m_axis_tready is high, and the next
// tick is accepted while the results of the previous one are still being sent. Configuration
// writes take effect on the next tick and are meant to be made while no tick is in flight.
module ultrasonic_ranging_controller_unit #(
	parameter int NUM_SENSORS = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [urc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [urc_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// Fields from bit 0: echo_levels[1:0], zero fill.
	input  logic [urc_pkg::IN_W-1:0]            s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// Fields from bit 0: sensor_index[2:0], trigger_level, distance_sixteenths[15:0],
	// distance_valid, event_code[1:0], zero fill.
	output logic [urc_pkg::OUT_W-1:0]           m_axis_tdata,
	output logic                                m_axis_tlast
);

	urc_pkg::urc_cfg_t cfg_q;
	urc_pkg::urc_res_t lane_res [NUM_SENSORS];
	logic              s1_valid_q;
	logic              step;
	logic              advance;
	logic              can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period  <= urc_pkg::PERIOD_RST;
			cfg_q.timeout <= urc_pkg::TIMEOUT_RST;
			cfg_q.setup   <= urc_pkg::SETUP_RST;
			cfg_q.pulse   <= urc_pkg::PULSE_RST;
			cfg_q.scale   <= urc_pkg::SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				urc_pkg::REG_PERIOD:  cfg_q.period  <= cfg_wdata;
				urc_pkg::REG_TIMEOUT: cfg_q.timeout <= cfg_wdata[15:0];
				urc_pkg::REG_SETUP:   cfg_q.setup   <= cfg_wdata[7:0];
				urc_pkg::REG_PULSE:   cfg_q.pulse   <= cfg_wdata[7:0];
				urc_pkg::REG_SCALE:   cfg_q.scale   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign advance       = s1_valid_q && can_load;
	assign s_axis_tready = !s1_valid_q || advance;
	assign step          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (step) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
		logic echo;
		if (i < urc_pkg::ECHO_BITS) begin : g_echo
			assign echo = s_axis_tdata[i];
		end else begin : g_no_echo
			assign echo = 1'b0;
		end
		urc_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (step),
			.advance (advance),
			.echo    (echo),
			.cfg     (cfg_q),
			.res     (lane_res[i])
		);
	end

	urc_merge #(
		.NUM_SENSORS (NUM_SENSORS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.lane_res (lane_res),
		.tready   (m_axis_tready),
		.tvalid   (m_axis_tvalid),
		.tdata    (m_axis_tdata),
		.tlast    (m_axis_tlast),
		.can_load (can_load)
	);

endmodule

FILE: rtl/urc_lane.sv
// One sensor lane: the ranging state machine, its counter and the distance multiply.
module urc_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              advance,
	input  logic              echo,
	input  urc_pkg::urc_cfg_t cfg,
	output urc_pkg::urc_res_t res
);

	logic [2:0]                     mode_q, mode_d;
	logic [urc_pkg::ELAPSED_W-1:0]  elapsed_q, elapsed_d, t;
	logic                           trig_q, trig_d;
	logic                           valid_q, valid_d;
	logic [urc_pkg::DIST_W-1:0]     dist_q;
	logic [1:0]                     ev_d;
	logic                           good_d;

	logic                           trig_s1;
	logic                           valid_s1;
	logic [1:0]                     ev_s1;
	logic                           good_s1;
	logic [15:0]                    width_s1;

	logic [31:0]                    prod;
	logic [urc_pkg::DIST_W-1:0]     dist_new;

	always_comb begin
		t         = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
		mode_d    = mode_q;
		elapsed_d = t;
		trig_d    = trig_q;
		valid_d   = valid_q;
		ev_d      = urc_pkg::EV_NONE;
		good_d    = 1'b0;
		unique case (mode_q)
			urc_pkg::MODE_IDLE: begin
				if (t >= cfg.period) begin
					trig_d    = 1'b0;
					mode_d    = urc_pkg::MODE_TRIG_LOW;
					elapsed_d = '0;
				end
			end
			urc_pkg::MODE_TRIG_LOW: begin
				if (t >= {12'd0, cfg.setup}) begin
					trig_d    = 1'b1;
					mode_d    = urc_pkg::MODE_TRIG_HIGH;
					elapsed_d = '0;
				end
			end
			urc_pkg::MODE_TRIG_HIGH: begin
				if (t >= {12'd0, cfg.pulse}) begin
					trig_d    = 1'b0;
					mode_d    = urc_pkg::MODE_WAIT_RISE;
					elapsed_d = '0;
				end
			end
			urc_pkg::MODE_WAIT_RISE: begin
				if (echo) begin
					mode_d    = urc_pkg::MODE_WAIT_FALL;
					elapsed_d = '0;
				end else if (t >= {4'd0, cfg.timeout}) begin
					valid_d   = 1'b0;
					ev_d      = urc_pkg::EV_FAIL;
					mode_d    = urc_pkg::MODE_IDLE;
					elapsed_d = '0;
				end
			end
			urc_pkg::MODE_WAIT_FALL: begin
				if (!echo) begin
					if (t != '0 && t < {4'd0, cfg.timeout}) begin
						good_d  = 1'b1;
						valid_d = 1'b1;
						ev_d    = urc_pkg::EV_DONE;
					end else begin
						valid_d = 1'b0;
						ev_d    = urc_pkg::EV_FAIL;
					end
					mode_d    = urc_pkg::MODE_IDLE;
					elapsed_d = '0;
				end else if (t >= {4'd0, cfg.timeout}) begin
					valid_d   = 1'b0;
					ev_d      = urc_pkg::EV_FAIL;
					mode_d    = urc_pkg::MODE_IDLE;
					elapsed_d = '0;
				end
			end
			default: begin
				trig_d    = 1'b0;
				mode_d    = urc_pkg::MODE_IDLE;
				elapsed_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= urc_pkg::MODE_IDLE;
			elapsed_q <= '0;
			trig_q    <= 1'b0;
			valid_q   <= 1'b0;
		end else if (step) begin
			mode_q    <= mode_d;
			elapsed_q <= elapsed_d;
			trig_q    <= trig_d;
			valid_q   <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			trig_s1  <= trig_d;
			valid_s1 <= valid_d;
			ev_s1    <= ev_d;
			good_s1  <= good_d;
			width_s1 <= t[15:0];
		end
	end

	// A good width is below the timeout, so the product shifted down always fits 16 bits.
	assign prod     = {16'd0, width_s1} * {16'd0, cfg.scale};
	assign dist_new = good_s1 ? prod[31:16] : dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
		end else if (advance) begin
			dist_q <= dist_new;
		end
	end

	always_comb begin
		res.trig     = trig_s1;
		res.distance = dist_new;
		res.valid    = valid_s1;
		res.ev       = ev_s1;
	end

endmodule

FILE: rtl/urc_merge.sv
// Result bank that collects the lane results of one tick and sends them out in sensor order.
module urc_merge #(
	parameter int NUM_SENSORS = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  urc_pkg::urc_res_t           lane_res [NUM_SENSORS],
	input  logic                        tready,
	output logic                        tvalid,
	output logic [urc_pkg::OUT_W-1:0]   tdata,
	output logic                        tlast,
	output logic                        can_load
);

	localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SENSORS - 1);

	urc_pkg::urc_res_t bank_q [NUM_SENSORS];
	logic              bank_valid_q;
	logic [IDX_W-1:0]  idx_q;
	urc_pkg::urc_res_t sel;
	logic              take;
	logic              is_last;

	assign take     = bank_valid_q && tready;
	assign is_last  = (idx_q == LAST_IDX);
	assign can_load = !bank_valid_q || (take && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_valid_q <= 1'b0;
			idx_q        <= '0;
		end else if (load) begin
			bank_valid_q <= 1'b1;
			idx_q        <= '0;
		end else if (take && is_last) begin
			bank_valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bank_q <= lane_res;
		end
	end

	assign sel    = bank_q[idx_q];
	assign tvalid = bank_valid_q;
	assign tlast  = is_last;
	assign tdata  = {1'b0, sel.ev, sel.valid, sel.distance, sel.trig, 3'(idx_q)};

endmodule

FILE: rtl/urc_checker.sv
// Port checker for the ultrasonic ranging controller and its bind to the top level.
module urc_checker #(
	parameter int NUM_SENSORS = 2
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [urc_pkg::OUT_W-1:0]   m_axis_tdata,
	input logic                        m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled result item changed.");

	a_next_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tvalid && (m_axis_tdata[2:0] == $past(m_axis_tdata[2:0]) + 3'd1))
		else $error("Result items of a tick are not in sensor order.");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2:0] == 3'(NUM_SENSORS - 1))
		else $error("Last item of a tick does not belong to the last sensor.");

	a_event_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(m_axis_tdata[22:21] == urc_pkg::EV_NONE) ||
		(m_axis_tdata[22:21] == urc_pkg::EV_DONE && m_axis_tdata[20]) ||
		(m_axis_tdata[22:21] == urc_pkg::EV_FAIL && !m_axis_tdata[20]))
		else $error("Event code and valid flag disagree.");

endmodule

bind ultrasonic_ranging_controller_unit urc_checker #(
	.NUM_SENSORS (NUM_SENSORS)
) u_urc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: sim/tb_ultrasonic_ranging_controller_unit.sv
// Testbench for the ultrasonic ranging controller: per-tick prediction, stream checks, watchdog.
`timescale 1ns / 100ps

class ranging_scoreboard #(int SENSORS = 2);
	logic [19:0] period;
	logic [15:0] timeout;
	logic [7:0]  setup;
	logic [7:0]  pulse;
	logic [15:0] scale;

	logic [2:0]  mode     [SENSORS];
	logic [19:0] elapsed  [SENSORS];
	logic [15:0] distance [SENSORS];
	logic        valid    [SENSORS];
	logic        trig     [SENSORS];

	// Each entry holds tlast above the 24 bits of tdata.
	logic [24:0] expected_results [$];
	int errors;

	function new();
		period  = urc_pkg::PERIOD_RST;
		timeout = urc_pkg::TIMEOUT_RST;
		setup   = urc_pkg::SETUP_RST;
		pulse   = urc_pkg::PULSE_RST;
		scale   = urc_pkg::SCALE_RST;
		for (int s = 0; s < SENSORS; s++) begin
			mode[s]     = urc_pkg::MODE_IDLE;
			elapsed[s]  = '0;
			distance[s] = '0;
			valid[s]    = 1'b0;
			trig[s]     = 1'b0;
		end
		errors = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [19:0] val);
		case (idx)
			urc_pkg::REG_PERIOD:  period  = val;
			urc_pkg::REG_TIMEOUT: timeout = val[15:0];
			urc_pkg::REG_SETUP:   setup   = val[7:0];
			urc_pkg::REG_PULSE:   pulse   = val[7:0];
			urc_pkg::REG_SCALE:   scale   = val[15:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

	function void enter(int s, logic [2:0] m);
		mode[s]    = m;
		elapsed[s] = '0;
	endfunction

	// Steps every sensor by one tick and queues one result per sensor.
	function void note_tick(logic [1:0] echo);
		logic        hit;
		logic [1:0]  ev;
		logic [19:0] t;
		logic [35:0] prod;
		logic [2:0]  idx;
		for (int s = 0; s < SENSORS; s++) begin
			hit = (s < urc_pkg::ECHO_BITS) ? echo[s] : 1'b0;
			ev  = urc_pkg::EV_NONE;
			if (elapsed[s] != {urc_pkg::ELAPSED_W{1'b1}})
				elapsed[s] = elapsed[s] + 20'd1;
			t = elapsed[s];
			case (mode[s])
				urc_pkg::MODE_IDLE: begin
					if (t >= period) begin
						trig[s] = 1'b0;
						enter(s, urc_pkg::MODE_TRIG_LOW);
					end
				end
				urc_pkg::MODE_TRIG_LOW: begin
					if (t >= 20'(setup)) begin
						trig[s] = 1'b1;
						enter(s, urc_pkg::MODE_TRIG_HIGH);
					end
				end
				urc_pkg::MODE_TRIG_HIGH: begin
					if (t >= 20'(pulse)) begin
						trig[s] = 1'b0;
						enter(s, urc_pkg::MODE_WAIT_RISE);
					end
				end
				urc_pkg::MODE_WAIT_RISE: begin
					if (hit) begin
						enter(s, urc_pkg::MODE_WAIT_FALL);
					end else if (t >= 20'(timeout)) begin
						valid[s] = 1'b0;
						ev = urc_pkg::EV_FAIL;
						enter(s, urc_pkg::MODE_IDLE);
					end
				end
				urc_pkg::MODE_WAIT_FALL: begin
					if (!hit) begin
						if (t != 0 && t < 20'(timeout)) begin
							prod = (36'(t) * 36'(scale)) >> 16;
							distance[s] = (prod > 36'hFFFF) ? 16'hFFFF : prod[15:0];
							valid[s] = 1'b1;
							ev = urc_pkg::EV_DONE;
						end else begin
							valid[s] = 1'b0;
							ev = urc_pkg::EV_FAIL;
						end
						enter(s, urc_pkg::MODE_IDLE);
					end else if (t >= 20'(timeout)) begin
						valid[s] = 1'b0;
						ev = urc_pkg::EV_FAIL;
						enter(s, urc_pkg::MODE_IDLE);
					end
				end
				default: begin
					trig[s] = 1'b0;
					enter(s, urc_pkg::MODE_IDLE);
				end
			endcase
			idx = 3'(s);
			expected_results.push_back({(s == SENSORS - 1), 1'b0, ev, valid[s], distance[s],
				trig[s], idx});
		end
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_result(logic [23:0] data, logic last);
		logic [24:0] want;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result item, expected none, actual tdata %h", $time, data);
			errors++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("sensor_index", want[2:0], data[2:0]);
		compare_field("trigger_level", want[3], data[3]);
		compare_field("distance_sixteenths", want[19:4], data[19:4]);
		compare_field("distance_valid", want[20], data[20]);
		compare_field("event_code", want[22:21], data[22:21]);
		compare_field("tdata fill", want[23], data[23]);
		compare_field("last_of_tick", want[24], last);
	endfunction
endclass

module tb_ultrasonic_ranging_controller_unit;

	localparam int NUM_SENSORS  = 2;
	localparam int RESET_CYCLES = 5;
	localparam int SETTLE       = 6;
	localparam int LONG_HOLD    = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int RAND_PHASES  = 5;
	localparam int PHASE_TICKS  = 27;
	localparam int N_DIRECTED   = 17;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [urc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [urc_pkg::CFG_W-1:0]     cfg_wdata;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [urc_pkg::IN_W-1:0]      s_axis_tdata;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [urc_pkg::OUT_W-1:0]     m_axis_tdata;
	logic                          m_axis_tlast;

	ranging_scoreboard #(NUM_SENSORS) sb;
	bit no_idle;
	bit hold_output;
	int quiet_cycles;

	// Walks sensor 0 through a good echo and timeouts in the rise wait, and sensor 1 through a rise
	// that wins over the timeout, a timeout in the fall wait and an echo that falls exactly at the timeout.
	logic [1:0] directed_echo [N_DIRECTED] = '{
		2'd3, 2'd0, 2'd3, 2'd1, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd0, 2'd0
	};

	ultrasonic_ranging_controller_unit #(.NUM_SENSORS(NUM_SENSORS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_ultrasonic_ranging_controller_unit: done, errors");
			$finish;
		end
	end

	task automatic send_tick(input logic [1:0] echo);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(urc_pkg::IN_W - 2){1'b0}}, echo};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_tick(echo);
	endtask

	task automatic write_one(input logic [urc_pkg::CFG_IDX_W-1:0] idx,
			input logic [urc_pkg::CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// Upper bits beyond each register's width carry junk that the block must mask off.
	task automatic apply_config(input logic [19:0] period, input logic [15:0] timeout,
			input logic [7:0] setup, input logic [7:0] pulse, input logic [15:0] scale);
		write_one(urc_pkg::REG_PERIOD, period);
		write_one(urc_pkg::REG_TIMEOUT, {4'($urandom), timeout});
		write_one(urc_pkg::REG_SETUP, {12'($urandom), setup});
		write_one(urc_pkg::REG_PULSE, {12'($urandom), pulse});
		write_one(urc_pkg::REG_SCALE, {4'($urandom), scale});
		write_one(urc_pkg::REG_SCALE + 3'($urandom_range(1, 3)), 20'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : result_sink
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				m_axis_tready <= 1'b0;
				for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
				hold_output = 1'b0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			sb.check_result(m_axis_tdata, m_axis_tlast);
		end
	end

	initial begin : stimulus
		logic [1:0] level;
		int         run_left [2];
		logic [15:0] scale;
		sb = new();
		no_idle       = 1'b0;
		hold_output   = 1'b0;
		quiet_cycles  = 0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= urc_pkg::REG_PERIOD;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings keep both sensors idle.
		send_tick(2'd3);
		send_tick(2'd0);
		send_tick(2'd1);
		drain();

		apply_config(20'd1, 16'd3, 8'd0, 8'd1, 16'hFFFF);
		for (int i = 0; i < N_DIRECTED; i++)
			send_tick(directed_echo[i]);
		drain();

		// All-zero registers: every compare holds on the first tick.
		apply_config(20'd0, 16'd0, 8'd0, 8'd0, 16'd0);
		send_tick(2'd3);
		send_tick(2'd0);
		send_tick(2'd1);
		send_tick(2'd2);
		drain();

		apply_config(20'hFFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_tick(2'd3);
		send_tick(2'd0);
		drain();

		// Echo levels are held for random runs so that rises and falls land at every point
		// of the wait states; now and then a tick carries noise instead.
		level = 2'($urandom);
		run_left[0] = 0;
		run_left[1] = 0;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 3)
				scale = 16'd0;
			else if (ph == 4)
				scale = 16'hFFFF;
			else
				scale = 16'($urandom);
			apply_config(20'($urandom_range(1, 8)), 16'($urandom_range(1, 12)),
				8'($urandom_range(0, 3)), 8'($urandom_range(1, 3)), scale);
			no_idle = (ph == 1);
			if (ph == 2)
				hold_output = 1'b1;
			for (int k = 0; k < PHASE_TICKS; k++) begin
				for (int s = 0; s < 2; s++) begin
					if (run_left[s] == 0) begin
						level[s]    = ~level[s];
						run_left[s] = $urandom_range(1, 10);
					end
					run_left[s]--;
				end
				if ($urandom_range(0, 9) == 0)
					send_tick(2'($urandom));
				else
					send_tick(level);
			end
			drain();
		end
		no_idle = 1'b0;

		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_ultrasonic_ranging_controller_unit: done, clean");
		else
			$display("tb_ultrasonic_ranging_controller_unit: done, errors");
		$finish;
	end

endmodule
